FILE: rtl/ljpr_pkg.sv
// Shared types, constants and shape decode functions of the lossless JPEG pixel rebuild unit.
package ljpr_pkg;

  // Sample and coordinate widths.
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 16;
  // Position counters and the 16-bit configuration fields.
  localparam int POS_BITS    = 16;
  localparam int DIFF_BITS   = 17;
  localparam int INIT_BITS   = 64;
  localparam int PRED_SLOT   = 16;
  localparam int NUM_COMPS   = 4;
  localparam int COMP_BITS   = 2;

  // Reciprocal of three scaled by 2^17, for the ceiling divide by three.
  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MCU_SHAPE          = 3'd0,
    REG_FRAME_MCUS_PER_ROW = 3'd1,
    REG_TILE_WIDTH         = 3'd2,
    REG_TILE_HEIGHT        = 3'd3,
    REG_ROWS_PER_RESTART   = 3'd4,
    REG_INITIAL_PREDICTORS = 3'd5
  } cfg_reg_t;

  // MCU layout codes.
  typedef enum logic [2:0] {
    SHAPE_1X1 = 3'd0,
    SHAPE_2X1 = 3'd1,
    SHAPE_3X1 = 3'd2,
    SHAPE_4X1 = 3'd3,
    SHAPE_2X2 = 3'd4
  } mcu_shape_t;

  // Settings seen by the reconstruction core, some of them precomputed.
  typedef struct packed {
    logic [2:0]           mcu_w;
    logic [1:0]           mcu_h;
    logic [2:0]           mcu_n;
    logic [POS_BITS-1:0]  tile_width;
    logic [POS_BITS-1:0]  tile_height;
    logic [POS_BITS-1:0]  consumed;
    logic [POS_BITS-1:0]  row_len;
    logic [POS_BITS-1:0]  restart_rows;
    logic [INIT_BITS-1:0] init_pred;
  } ljpr_cfg_t;

  // One result item.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pixel;
    logic [COORD_BITS-1:0]  out_row;
    logic [COORD_BITS-1:0]  out_column;
    logic                   tile_last;
  } ljpr_res_t;

  // MCU width in components; unknown codes act as 1x1.
  function automatic logic [2:0] shape_width(logic [2:0] shape);
    logic [2:0] w;
    case (shape)
      SHAPE_2X1: w = 3'd2;
      SHAPE_3X1: w = 3'd3;
      SHAPE_4X1: w = 3'd4;
      SHAPE_2X2: w = 3'd2;
      default:   w = 3'd1;
    endcase
    return w;
  endfunction

  // MCU height in rows.
  function automatic logic [1:0] shape_height(logic [2:0] shape);
    return (shape == SHAPE_2X2) ? 2'd2 : 2'd1;
  endfunction

  // Components in one MCU.
  function automatic logic [2:0] shape_count(logic [2:0] shape);
    logic [2:0] n;
    case (shape)
      SHAPE_2X1: n = 3'd2;
      SHAPE_3X1: n = 3'd3;
      SHAPE_4X1: n = 3'd4;
      SHAPE_2X2: n = 3'd4;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/ljpr_ifs.sv
// Valid/ready channel interfaces for differences, pixels and configuration writes.
interface ljpr_diff_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ljpr_pkg::DIFF_BITS-1:0] difference;
  modport source (output valid, output difference, input ready);
  modport sink   (input valid, input difference, output ready);
endinterface

interface ljpr_pix_if;
  logic                             valid;
  logic                             ready;
  logic [ljpr_pkg::SAMPLE_BITS-1:0] pixel;
  logic [ljpr_pkg::COORD_BITS-1:0]  out_row;
  logic [ljpr_pkg::COORD_BITS-1:0]  out_column;
  logic                             tile_last;
  modport source (output valid, output pixel, output out_row, output out_column,
                  output tile_last, input ready);
  modport sink   (input valid, input pixel, input out_row, input out_column,
                  input tile_last, output ready);
endinterface

interface ljpr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     index;
  logic [ljpr_pkg::INIT_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lossless_jpeg_pixel_rebuild_unit.sv
// Top level of the lossless JPEG pixel rebuild unit (predictor one reconstruction).
// A pixel goes from its difference transaction into the output register, or the skid
// stage while the output stalls. Throughput: one difference per cycle while the skid
// stage is free and settings are stable, set by the single add and position update.
// A configuration write holds off differences while the row geometry registers settle;
// synchronous reset does too, sets the defaults and clears positions and predictors.
module lossless_jpeg_pixel_rebuild_unit (
  input  logic       clk,
  input  logic       rst,
  ljpr_cfg_if.sink   cfg_ch,
  ljpr_diff_if.sink  diff_ch,
  ljpr_pix_if.source pixel_ch
);

  ljpr_pkg::ljpr_cfg_t cfg;
  ljpr_pkg::ljpr_res_t res;
  logic                cfg_busy;
  logic                buf_full;
  logic                res_valid;
  logic                take;

  ljpr_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg),
    .busy   (cfg_busy)
  );

  // Accept a difference whenever the skid stage is free and the settings are stable.
  assign diff_ch.ready = ~buf_full & ~cfg_busy;
  assign take          = diff_ch.valid & diff_ch.ready;

  ljpr_rebuild u_rebuild (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .difference (diff_ch.difference),
    .res_valid  (res_valid),
    .res        (res)
  );

  ljpr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .pixel_ch  (pixel_ch)
  );

endmodule

FILE: rtl/ljpr_cfg_regs.sv
// Configuration registers and the row geometry derived from them.
module ljpr_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  ljpr_cfg_if.sink            cfg_ch,
  output ljpr_pkg::ljpr_cfg_t cfg,
  output logic                busy
);

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  logic [2:0]                     mcu_shape;
  logic [ljpr_pkg::POS_BITS-1:0]  frame_mcus_per_row;
  logic [ljpr_pkg::POS_BITS-1:0]  tile_width;
  logic [ljpr_pkg::POS_BITS-1:0]  tile_height;
  logic [ljpr_pkg::POS_BITS-1:0]  rows_per_restart;
  logic [ljpr_pkg::INIT_BITS-1:0] initial_predictors;

  logic [ljpr_pkg::POS_BITS-1:0]  consumed;
  logic [ljpr_pkg::POS_BITS-1:0]  consumed_next;
  logic [ljpr_pkg::POS_BITS-1:0]  row_len;
  logic [ljpr_pkg::POS_BITS-1:0]  row_len_next;
  logic [1:0]                     settle;

  logic                           wr;
  logic [ljpr_pkg::POS_BITS:0]    width_sum;
  logic [33:0]                    div3_prod;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid & cfg_ch.ready;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      mcu_shape          <= ljpr_pkg::SHAPE_1X1;
      frame_mcus_per_row <= 16'd1;
      tile_width         <= 16'd1;
      tile_height        <= 16'd1;
      rows_per_restart   <= 16'd1;
      initial_predictors <= '0;
    end else if (wr) begin
      unique case (cfg_ch.index)
        ljpr_pkg::REG_MCU_SHAPE:          mcu_shape <= cfg_ch.data[2:0];
        ljpr_pkg::REG_FRAME_MCUS_PER_ROW: frame_mcus_per_row <= cfg_ch.data[15:0];
        ljpr_pkg::REG_TILE_WIDTH:         tile_width <= cfg_ch.data[15:0];
        ljpr_pkg::REG_TILE_HEIGHT:        tile_height <= cfg_ch.data[15:0];
        ljpr_pkg::REG_ROWS_PER_RESTART:   rows_per_restart <= cfg_ch.data[15:0];
        ljpr_pkg::REG_INITIAL_PREDICTORS: initial_predictors <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // MCUs that cover the tile width: ceil(tile_width / w), with a reciprocal for w of three.
  assign width_sum = {1'b0, tile_width} +
                     {14'd0, ljpr_pkg::shape_width(mcu_shape) - 3'd1};
  assign div3_prod = {17'd0, width_sum} * {17'd0, ljpr_pkg::DIV3_RECIP};

  always_comb begin
    case (ljpr_pkg::shape_width(mcu_shape))
      3'd2:    consumed_next = width_sum[16:1];
      3'd3:    consumed_next = div3_prod[ljpr_pkg::DIV3_SHIFT +: ljpr_pkg::POS_BITS];
      3'd4:    consumed_next = {1'b0, width_sum[16:2]};
      default: consumed_next = tile_width;
    endcase
  end

  // A row takes the longer of the coded and the covered lengths, and at least one MCU.
  always_comb begin
    row_len_next = (frame_mcus_per_row > consumed) ? frame_mcus_per_row : consumed;
    if (row_len_next == '0) begin
      row_len_next = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    consumed <= consumed_next;
    row_len  <= row_len_next;
  end

  // Hold off items until the derived values have passed through their registers.
  always_ff @(posedge clk) begin
    if (rst || wr) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy = (settle != 2'd0);

  always_comb begin
    cfg.mcu_w        = ljpr_pkg::shape_width(mcu_shape);
    cfg.mcu_h        = ljpr_pkg::shape_height(mcu_shape);
    cfg.mcu_n        = ljpr_pkg::shape_count(mcu_shape);
    cfg.tile_width   = tile_width;
    cfg.tile_height  = tile_height;
    cfg.consumed     = consumed;
    cfg.row_len      = row_len;
    cfg.restart_rows = (rows_per_restart == '0) ? 16'd1 : rows_per_restart;
    cfg.init_pred    = initial_predictors;
  end

endmodule

FILE: rtl/ljpr_rebuild.sv
// Predictor selection, sample add, tile position tracking and last-sample detection.
module ljpr_rebuild (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ljpr_pkg::ljpr_cfg_t                   cfg,
  input  logic                                  take,
  input  logic signed [ljpr_pkg::DIFF_BITS-1:0] difference,
  output logic                                  res_valid,
  output ljpr_pkg::ljpr_res_t                   res
);

  logic [ljpr_pkg::SAMPLE_BITS-1:0] running [ljpr_pkg::NUM_COMPS];
  logic [ljpr_pkg::SAMPLE_BITS-1:0] row_start [ljpr_pkg::NUM_COMPS];
  logic [ljpr_pkg::COMP_BITS-1:0]   comp_pos;
  logic [ljpr_pkg::POS_BITS-1:0]    mcu_pos;
  logic [ljpr_pkg::POS_BITS-1:0]    mcu_row;
  logic [ljpr_pkg::POS_BITS-1:0]    interval_row;

  logic [ljpr_pkg::COMP_BITS-1:0]   comp;
  logic [ljpr_pkg::POS_BITS:0]      base_row;
  logic                             finished;
  logic [17:0]                      mcu_col;
  logic [ljpr_pkg::NUM_COMPS-1:0]   in_tile;
  logic [ljpr_pkg::NUM_COMPS-1:0]   later_in;
  logic [ljpr_pkg::SAMPLE_BITS-1:0] pred;
  logic [ljpr_pkg::SAMPLE_BITS-1:0] pix;
  logic [1:0]                       col_off;
  logic                             row_off;
  logic [17:0]                      col_full;
  logic [ljpr_pkg::POS_BITS:0]      row_full;
  logic [ljpr_pkg::POS_BITS+1:0]    row_end;
  logic                             last;
  logic [2:0]                       comp_inc;
  logic [ljpr_pkg::POS_BITS:0]      mcu_inc;
  logic [ljpr_pkg::POS_BITS:0]      interval_inc;
  logic                             step;

  // Where the current MCU row starts and whether the tile is already done.
  assign base_row = (cfg.mcu_h == 2'd2) ? {mcu_row, 1'b0} : {1'b0, mcu_row};
  assign finished = (base_row >= {1'b0, cfg.tile_height});
  assign comp     = ({1'b0, comp_pos} < cfg.mcu_n) ? comp_pos : '0;
  assign step     = take & ~finished;

  // First component column of the current MCU.
  always_comb begin
    case (cfg.mcu_w)
      3'd2:    mcu_col = {1'b0, mcu_pos, 1'b0};
      3'd3:    mcu_col = {1'b0, mcu_pos, 1'b0} + {2'b00, mcu_pos};
      3'd4:    mcu_col = {mcu_pos, 2'b00};
      default: mcu_col = {2'b00, mcu_pos};
    endcase
  end

  // Tile membership of each component of the MCU, for emit and last decisions.
  always_comb begin
    for (int c = 0; c < ljpr_pkg::NUM_COMPS; c++) begin
      logic [1:0] c_col;
      logic       c_row;
      logic [2:0] c_idx;
      c_idx = 3'(c);
      if (cfg.mcu_h == 2'd2) begin
        c_col = {1'b0, c_idx[0]};
        c_row = c_idx[1];
      end else begin
        c_col = c_idx[1:0];
        c_row = 1'b0;
      end
      in_tile[c] = ((mcu_col + {16'd0, c_col}) < {2'b00, cfg.tile_width}) &&
                   ((base_row + {16'd0, c_row}) < {1'b0, cfg.tile_height});
      later_in[c] = in_tile[c] && (c_idx > {1'b0, comp}) && (c_idx < cfg.mcu_n);
    end
  end

  // Offsets of the current component inside its MCU.
  always_comb begin
    if (cfg.mcu_h == 2'd2) begin
      col_off = {1'b0, comp[0]};
      row_off = comp[1];
    end else begin
      col_off = comp;
      row_off = 1'b0;
    end
  end

  assign col_full = mcu_col + {16'd0, col_off};
  assign row_full = base_row + {16'd0, row_off};
  assign row_end  = {1'b0, base_row} + {16'd0, cfg.mcu_h};
  assign last     = (row_end >= {2'b00, cfg.tile_height}) &&
                    ({1'b0, mcu_pos} + 17'd1 == {1'b0, cfg.consumed}) &&
                    (later_in == '0);

  // Predictor: initial value at an interval start, row start at a row start, else left MCU.
  always_comb begin
    if (mcu_pos == '0) begin
      if (interval_row == '0) begin
        pred = cfg.init_pred[{comp, 4'b0000} +: ljpr_pkg::SAMPLE_BITS];
      end else begin
        pred = row_start[comp];
      end
    end else begin
      pred = running[comp];
    end
  end

  assign pix = pred + difference[ljpr_pkg::SAMPLE_BITS-1:0];

  // Result handed to the output buffer in the cycle of the transaction.
  assign res_valid      = step & in_tile[comp];
  assign res.pixel      = pix;
  assign res.out_row    = row_full[ljpr_pkg::COORD_BITS-1:0];
  assign res.out_column = col_full[ljpr_pkg::COORD_BITS-1:0];
  assign res.tile_last  = last;

  // Predictor stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ljpr_pkg::NUM_COMPS; i++) begin
        running[i]   <= '0;
        row_start[i] <= '0;
      end
    end else if (step) begin
      running[comp] <= pix;
      if (mcu_pos == '0) begin
        row_start[comp] <= pix;
      end
    end
  end

  // Position advance: component, then MCU, then MCU row and restart interval.
  assign comp_inc     = {1'b0, comp} + 3'd1;
  assign mcu_inc      = {1'b0, mcu_pos} + 17'd1;
  assign interval_inc = {1'b0, interval_row} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_pos     <= '0;
      mcu_pos      <= '0;
      mcu_row      <= '0;
      interval_row <= '0;
    end else if (step) begin
      if (comp_inc >= cfg.mcu_n) begin
        comp_pos <= '0;
        if (mcu_inc >= {1'b0, cfg.row_len}) begin
          mcu_pos <= '0;
          mcu_row <= mcu_row + 16'd1;
          if (interval_inc >= {1'b0, cfg.restart_rows}) begin
            interval_row <= '0;
          end else begin
            interval_row <= interval_inc[ljpr_pkg::POS_BITS-1:0];
          end
        end else begin
          mcu_pos <= mcu_inc[ljpr_pkg::POS_BITS-1:0];
        end
      end else begin
        comp_pos <= comp_inc[ljpr_pkg::COMP_BITS-1:0];
      end
    end
  end

endmodule

FILE: rtl/ljpr_out_buf.sv
// Output register with a skid stage that decouples input acceptance from output stalls.
module ljpr_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ljpr_pkg::ljpr_res_t push_data,
  output logic                full,
  ljpr_pix_if.source          pixel_ch
);

  logic                out_valid;
  ljpr_pkg::ljpr_res_t out_data;
  logic                skid_valid;
  ljpr_pkg::ljpr_res_t skid_data;
  logic                pop;
  logic                load_out;
  logic                load_skid;

  assign pop       = out_valid & pixel_ch.ready;
  // The skid stage only fills while the output register is stalled.
  assign load_skid = push & ~skid_valid & out_valid & ~pop;
  assign load_out  = (skid_valid & pop) | (push & ~skid_valid & ~(out_valid & ~pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (pop) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (load_skid) begin
      skid_data <= push_data;
    end
  end

  assign full                = skid_valid;
  assign pixel_ch.valid      = out_valid;
  assign pixel_ch.pixel      = out_data.pixel;
  assign pixel_ch.out_row    = out_data.out_row;
  assign pixel_ch.out_column = out_data.out_column;
  assign pixel_ch.tile_last  = out_data.tile_last;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the lossless JPEG pixel rebuild unit, with its own pixel predictor.
module tb_top;
  import ljpr_pkg::*;

  localparam int IDLE_LIMIT     = 3000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 3;
  localparam logic [DIFF_BITS-1:0] DIFF_MAX = 17'sd65535;
  localparam logic [DIFF_BITS-1:0] DIFF_MIN = -17'sd65535;

  // One complete register setting for a tile.
  typedef struct {
    logic [2:0]           shape;
    logic [POS_BITS-1:0]  frame_mcus;
    logic [POS_BITS-1:0]  tile_w;
    logic [POS_BITS-1:0]  tile_h;
    logic [POS_BITS-1:0]  restart_rows;
    logic [INIT_BITS-1:0] seeds;
  } tile_setup_t;

  logic clk = 1'b0;
  logic rst;

  ljpr_cfg_if  cfg_ch ();
  ljpr_diff_if diff_ch ();
  ljpr_pix_if  pixel_ch ();

  lossless_jpeg_pixel_rebuild_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_ch   (cfg_ch),
    .diff_ch  (diff_ch),
    .pixel_ch (pixel_ch)
  );

  // Register copy held by the predictor.
  logic [2:0]           cfg_shape;
  logic [POS_BITS-1:0]  cfg_frame_mcus;
  logic [POS_BITS-1:0]  cfg_tile_w;
  logic [POS_BITS-1:0]  cfg_tile_h;
  logic [POS_BITS-1:0]  cfg_restart_rows;
  logic [INIT_BITS-1:0] cfg_seed_preds;

  // Predictor state.
  logic [SAMPLE_BITS-1:0] left_pred [NUM_COMPS];
  logic [SAMPLE_BITS-1:0] row_head_pred [NUM_COMPS];
  logic [COMP_BITS-1:0]   comp_idx;
  int unsigned            mcu_col;
  int unsigned            mcu_row;
  int unsigned            restart_row;

  ljpr_res_t pending_pixels[$];
  ljpr_res_t seen_px;
  ljpr_res_t due_px;

  int  mismatches;
  int  pixels_checked;
  int  tile_ends;
  int  live_items;
  int  ignored_items;
  int  setups_loaded;
  int  idle_cycles;
  int  sink_hold;
  bit  source_gaps_on;
  bit  sink_stalls_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // MCU width in components and height in rows; unknown codes act as 1x1.
  function automatic int unsigned shape_cols(logic [2:0] shape);
    case (shape)
      SHAPE_2X1, SHAPE_2X2: return 2;
      SHAPE_3X1: return 3;
      SHAPE_4X1: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic int unsigned shape_lines(logic [2:0] shape);
    return (shape == SHAPE_2X2) ? 2 : 1;
  endfunction

  // True while the current MCU row still starts inside the tile.
  function automatic bit tile_open();
    return mcu_row * shape_lines(cfg_shape) < cfg_tile_h;
  endfunction

  // Tile height that ends the given number of rows below the current MCU row.
  function automatic logic [POS_BITS-1:0] rows_ahead(logic [2:0] shape, int unsigned lines);
    int unsigned v;
    v = mcu_row * shape_lines(shape) + lines;
    return (v > 65535) ? 16'hFFFF : v[POS_BITS-1:0];
  endfunction

  function automatic bit sample_in_tile(int unsigned w, int unsigned base_row,
                                        int unsigned mcu, int unsigned comp);
    return (w * mcu + comp % w < cfg_tile_w) && (base_row + comp / w < cfg_tile_h);
  endfunction

  // Rebuilds one sample from its difference and advances the MCU position.
  // Returns 1 when the sample lies inside the tile and is emitted.
  function automatic bit rebuild_sample(input logic [DIFF_BITS-1:0] diff, output ljpr_res_t px);
    int unsigned w, h, n, base_row, comp, c, mcus_kept, mcus_coded, restart;
    logic [SAMPLE_BITS-1:0] pred, rebuilt;
    bit emit, last;
    w = shape_cols(cfg_shape);
    h = shape_lines(cfg_shape);
    n = w * h;
    base_row = mcu_row * h;
    px = '0;
    emit = 1'b0;
    if (base_row >= cfg_tile_h)
      return 1'b0;
    // A component index left over from a larger MCU restarts at zero.
    comp = (comp_idx < n) ? comp_idx : 0;
    if (mcu_col == 0)
      pred = (restart_row == 0) ? cfg_seed_preds[PRED_SLOT*comp +: PRED_SLOT]
                                : row_head_pred[comp];
    else
      pred = left_pred[comp];
    rebuilt = pred + diff[SAMPLE_BITS-1:0];
    left_pred[comp] = rebuilt;
    if (mcu_col == 0)
      row_head_pred[comp] = rebuilt;
    mcus_kept = (cfg_tile_w + w - 1) / w;
    if (sample_in_tile(w, base_row, mcu_col, comp)) begin
      last = (base_row + h >= cfg_tile_h) && (mcu_col + 1 == mcus_kept);
      for (c = comp + 1; c < n; c++)
        if (sample_in_tile(w, base_row, mcu_col, c))
          last = 1'b0;
      px.pixel      = rebuilt;
      px.out_row    = 16'(base_row + comp / w);
      px.out_column = 16'(w * mcu_col + comp % w);
      px.tile_last  = last;
      emit = 1'b1;
    end
    // Advance; positions beyond a shrunk limit wrap at this step.
    mcus_coded = (cfg_frame_mcus > mcus_kept) ? cfg_frame_mcus : mcus_kept;
    if (mcus_coded == 0)
      mcus_coded = 1;
    restart = (cfg_restart_rows == 0) ? 1 : cfg_restart_rows;
    comp++;
    if (comp >= n) begin
      comp = 0;
      mcu_col++;
      if (mcu_col >= mcus_coded) begin
        mcu_col = 0;
        mcu_row = (mcu_row + 1) & 32'h0000_FFFF;
        restart_row++;
        if (restart_row >= restart)
          restart_row = 0;
      end
    end
    comp_idx = comp[COMP_BITS-1:0];
    return emit;
  endfunction

  // Stall lengths: mostly short, a few long.
  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    else if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Differences: mostly the full range, some small steps and the extremes.
  function automatic logic [DIFF_BITS-1:0] random_difference();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = 65535;
          default: v = -65535;
        endcase
      end
      1, 2: v = $urandom_range(0, 64) - 32;
      default: v = $urandom_range(0, 131070) - 65535;
    endcase
    return v[DIFF_BITS-1:0];
  endfunction

  // Sends one difference and predicts its pixel once the transaction completes.
  task automatic send_difference(input logic [DIFF_BITS-1:0] diff);
    int gap;
    ljpr_res_t px;
    bit live;
    gap = (source_gaps_on && $urandom_range(0, 99) < 35) ? stall_length() : 0;
    if (gap > 0) begin
      diff_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    diff_ch.valid      <= 1'b1;
    diff_ch.difference <= diff;
    do @(posedge clk); while (!diff_ch.ready);
    live = tile_open();
    if (rebuild_sample(diff, px))
      pending_pixels.push_back(px);
    if (live)
      live_items++;
    else
      ignored_items++;
  endtask

  // Stops the stream and waits until the block has nothing left in flight.
  task automatic settle_block();
    diff_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers valid after its last write.
  task automatic write_register(input cfg_reg_t idx, input logic [INIT_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MCU_SHAPE:          cfg_shape        = value[2:0];
      REG_FRAME_MCUS_PER_ROW: cfg_frame_mcus   = value[POS_BITS-1:0];
      REG_TILE_WIDTH:         cfg_tile_w       = value[POS_BITS-1:0];
      REG_TILE_HEIGHT:        cfg_tile_h       = value[POS_BITS-1:0];
      REG_ROWS_PER_RESTART:   cfg_restart_rows = value[POS_BITS-1:0];
      REG_INITIAL_PREDICTORS: cfg_seed_preds   = value;
      default: ;
    endcase
  endtask

  // Writes a whole setting and picks the idling style for the coming tile.
  task automatic load_setup(input tile_setup_t s);
    write_register(REG_MCU_SHAPE, 64'(s.shape));
    write_register(REG_FRAME_MCUS_PER_ROW, 64'(s.frame_mcus));
    write_register(REG_TILE_WIDTH, 64'(s.tile_w));
    write_register(REG_TILE_HEIGHT, 64'(s.tile_h));
    write_register(REG_ROWS_PER_RESTART, 64'(s.restart_rows));
    write_register(REG_INITIAL_PREDICTORS, s.seeds);
    cfg_ch.valid <= 1'b0;
    source_gaps_on = ($urandom_range(0, 3) != 0);
    sink_stalls_on = ($urandom_range(0, 3) != 0);
    setups_loaded++;
  endtask

  // Every shape code, unknown ones included, with a partial trailing MCU for wider shapes.
  // The 2x2 tile ends halfway through its MCU row.
  task automatic test_shapes();
    tile_setup_t s;
    int unsigned w;
    for (int k = 0; k < 8; k++) begin
      w = shape_cols(k[2:0]);
      s.shape        = k[2:0];
      s.tile_w       = 16'((w > 1) ? w + 1 : 1);
      s.frame_mcus   = (w > 1) ? 16'd1 : 16'd2;
      s.tile_h       = rows_ahead(s.shape, 1);
      s.restart_rows = 16'd2;
      s.seeds        = {$urandom, $urandom};
      load_setup(s);
      while (tile_open()) send_difference(random_difference());
      settle_block();
    end
  endtask

  // Extreme differences with wrapping sums; zero restart rows restart every row.
  // Two more differences after the tile end must be swallowed.
  task automatic test_sample_extremes();
    tile_setup_t s;
    s = '{shape: SHAPE_1X1, frame_mcus: 16'd2, tile_w: 16'd2,
          tile_h: rows_ahead(SHAPE_1X1, 3), restart_rows: 16'd0, seeds: '1};
    load_setup(s);
    send_difference(DIFF_MAX);
    send_difference(DIFF_MIN);
    send_difference('0);
    send_difference(17'd1);
    send_difference(-17'sd1);
    send_difference(DIFF_MAX);
    send_difference(DIFF_MIN);
    send_difference(17'd1);
    settle_block();
  endtask

  // A shape change in the middle of an MCU leaves a component index too large.
  task automatic test_stale_component();
    tile_setup_t s;
    s = '{shape: SHAPE_4X1, frame_mcus: 16'd2, tile_w: 16'd8,
          tile_h: rows_ahead(SHAPE_4X1, 1), restart_rows: 16'd1, seeds: {$urandom, $urandom}};
    load_setup(s);
    repeat (3) send_difference(random_difference());
    settle_block();
    write_register(REG_MCU_SHAPE, 64'(SHAPE_2X1));
    cfg_ch.valid <= 1'b0;
    while (tile_open()) send_difference(random_difference());
    settle_block();
  endtask

  // Row length and restart interval shrink below the current positions.
  task automatic test_shrunk_limits();
    tile_setup_t s;
    s = '{shape: SHAPE_1X1, frame_mcus: 16'd10, tile_w: 16'd10,
          tile_h: rows_ahead(SHAPE_1X1, 3), restart_rows: 16'd3, seeds: {$urandom, $urandom}};
    load_setup(s);
    repeat (17) send_difference(random_difference());
    settle_block();
    s.frame_mcus   = 16'd3;
    s.tile_w       = 16'd3;
    s.restart_rows = 16'd1;
    load_setup(s);
    while (tile_open()) send_difference(random_difference());
    settle_block();
  endtask

  // Largest register values; only the start of the current MCU row is sent.
  task automatic test_register_extremes();
    tile_setup_t s;
    s = '{shape: SHAPE_2X2, frame_mcus: 16'hFFFF, tile_w: 16'hFFFF,
          tile_h: 16'hFFFF, restart_rows: 16'hFFFF, seeds: '1};
    load_setup(s);
    repeat (10) send_difference(random_difference());
    settle_block();
  endtask

  // Random tiles, most run to their end, some cut short and some followed by
  // differences past the tile end.
  task automatic test_random_tiles();
    tile_setup_t s;
    int unsigned w, h, kept, lines, budget, target;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      s.shape = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
      w = shape_cols(s.shape);
      h = shape_lines(s.shape);
      s.tile_w = 16'($urandom_range(1, 5 * w));
      kept = (s.tile_w + w - 1) / w;
      case ($urandom_range(0, 3))
        0: s.frame_mcus = 16'($urandom_range(1, kept));
        1: s.frame_mcus = 16'(kept + $urandom_range(1, 3));
        default: s.frame_mcus = 16'(kept);
      endcase
      lines = $urandom_range(1, 4) * h;
      if (h == 2 && $urandom_range(0, 2) == 0)
        lines--;
      s.tile_h = rows_ahead(s.shape, lines);
      s.restart_rows = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 3));
      case ($urandom_range(0, 5))
        0: s.seeds = '0;
        1: s.seeds = '1;
        default: s.seeds = {$urandom, $urandom};
      endcase
      load_setup(s);
      budget = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 32'hFFFF_FFFF;
      while (tile_open() && budget > 0) begin
        send_difference(random_difference());
        budget--;
      end
      if (!tile_open() && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_difference(random_difference());
      settle_block();
    end
  endtask

  // Pixel sink: random stalls, with stretches of none.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      pixel_ch.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
      pixel_ch.ready <= 1'b0;
      sink_hold = stall_length() - 1;
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  // Each pixel transaction is checked against the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      seen_px.pixel      = pixel_ch.pixel;
      seen_px.out_row    = pixel_ch.out_row;
      seen_px.out_column = pixel_ch.out_column;
      seen_px.tile_last  = pixel_ch.tile_last;
      pixels_checked++;
      if (seen_px.tile_last === 1'b1)
        tile_ends++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel %h at row %0d column %0d last %b", seen_px.pixel,
                   seen_px.out_row, seen_px.out_column, seen_px.tile_last);
      end else begin
        due_px = pending_pixels.pop_front();
        if (seen_px.pixel !== due_px.pixel || seen_px.out_row !== due_px.out_row ||
            seen_px.out_column !== due_px.out_column ||
            seen_px.tile_last !== due_px.tile_last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"pixel mismatch: expected %h row %0d col %0d last %b, ",
                      "got %h row %0d col %0d last %b"},
                     due_px.pixel, due_px.out_row, due_px.out_column, due_px.tile_last,
                     seen_px.pixel, seen_px.out_row, seen_px.out_column, seen_px.tile_last);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((diff_ch.valid && diff_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d pixels still expected",
               IDLE_LIMIT, pending_pixels.size());
      $display("lossless_jpeg_pixel_rebuild_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    diff_ch.valid      = 1'b0;
    diff_ch.difference = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MCU_SHAPE;
    cfg_ch.data        = '0;
    pixel_ch.ready     = 1'b0;
    // Predictor starts from the reset state of the block.
    cfg_shape        = SHAPE_1X1;
    cfg_frame_mcus   = 16'd1;
    cfg_tile_w       = 16'd1;
    cfg_tile_h       = 16'd1;
    cfg_restart_rows = 16'd1;
    cfg_seed_preds   = '0;
    for (int i = 0; i < NUM_COMPS; i++) begin
      left_pred[i]     = '0;
      row_head_pred[i] = '0;
    end
    comp_idx       = '0;
    mcu_col        = 0;
    mcu_row        = 0;
    restart_row    = 0;
    mismatches     = 0;
    pixels_checked = 0;
    tile_ends      = 0;
    live_items     = 0;
    ignored_items  = 0;
    setups_loaded  = 0;
    idle_cycles    = 0;
    sink_hold      = 0;
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_shapes();
    test_sample_extremes();
    test_stale_component();
    test_shrunk_limits();
    test_register_extremes();
    test_random_tiles();

    settle_block();
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      mismatches += pending_pixels.size();
      $display("%0d expected pixels never arrived", pending_pixels.size());
    end
    $display("Ran %0d differences over %0d register settings, %0d of them past a tile end.",
             live_items + ignored_items, setups_loaded, ignored_items);
    $display("Checked %0d pixels and %0d tile ends; %0d mismatches.",
             pixels_checked, tile_ends, mismatches);
    if (mismatches == 0)
      $display("lossless_jpeg_pixel_rebuild_unit regression: pass");
    else
      $display("lossless_jpeg_pixel_rebuild_unit regression: fail");
    $finish;
  end

endmodule
